// ===== sv/best_fit_block_allocator_macros.svh =====
// Assertion macros shared by the best-fit block allocator.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bfa assertion failed");

// Next-cycle implication, checked out of reset.
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bfa assertion failed");

`endif

// ===== sv/bfa_pkg.sv =====
// Types, codes and defaults for the best-fit block allocator.
package bfa_pkg;

    localparam int MAX_BLOCKS_DEF = 16;
    localparam int CFG_W          = 5;
    localparam int IDX_FIELD_W    = 4;
    localparam int AMT_W          = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_REQ  = 1'b1;

    typedef struct packed {
        logic                   op;
        logic [IDX_FIELD_W-1:0] block_index;
        logic [AMT_W-1:0]       amount;
    } t_in_item;

    typedef struct packed {
        logic                   found;
        logic [IDX_FIELD_W-1:0] chosen_block;
        logic [AMT_W-1:0]       left_over;
    } t_out_item;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load_wr;
        logic req_start;
        logic scan_rd;
        logic finish;
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic limit_zero;
        logic scan_last;
    } t_dp_sts;

endpackage

// ===== sv/bfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/bfa_ctrl.sv =====
// Controller state machine for the best-fit block allocator.
module bfa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_op,
    input  bfa_pkg::t_dp_sts i_sts,
    output bfa_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);
    import bfa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state_e;

    t_state_e r_state, n_state;
    logic     r_busy;
    logic     w_accept;

    assign w_accept = i_start && !r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else begin
                        o_cmd.req_start = 1'b1;
                        n_state = i_sts.limit_zero ? S_FINISH : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== sv/bfa_dp.sv =====
// Datapath: capacity RAM, scan counter, best-fit compare and result register.
module bfa_dp #(
    parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bfa_pkg::t_in_item          i_item,
    input  logic                       i_cfg_we,
    input  logic [bfa_pkg::CFG_W-1:0]  i_cfg_data,
    input  bfa_pkg::t_dp_cmd           i_cmd,
    output bfa_pkg::t_dp_sts           o_sts,
    output bfa_pkg::t_out_item         o_result,
    output logic                       o_done
);
    import bfa_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LIM_W = IDX_W + 1;

    logic [CFG_W-1:0] r_block_count;
    logic [AMT_W-1:0] r_amount;
    logic [IDX_W-1:0] r_addr;
    logic [LIM_W-1:0] r_limit;
    logic             r_rd_valid;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_have;
    logic [IDX_W-1:0] r_best_idx;
    logic [AMT_W-1:0] r_best_cap;
    t_out_item        r_result;
    logic             r_done;

    logic [LIM_W-1:0] w_limit;
    logic [AMT_W-1:0] w_rd_data;
    logic             w_load_ok;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    logic [AMT_W-1:0] w_wr_data;
    logic [AMT_W-1:0] w_diff;
    logic             w_better;

    // Saturate the block count to the table depth.
    assign w_limit = (32'(r_block_count) > MAX_BLOCKS) ? LIM_W'(MAX_BLOCKS)
                                                      : LIM_W'(r_block_count);

    assign o_sts.limit_zero = (w_limit == '0);
    assign o_sts.scan_last  = ((LIM_W'(r_addr) + LIM_W'(1)) == r_limit);

    assign w_load_ok = (32'(i_item.block_index) < MAX_BLOCKS);
    assign w_diff    = r_best_cap - r_amount;
    assign w_better  = (w_rd_data >= r_amount) && (!r_have || (w_rd_data < r_best_cap));

    assign w_wr_en   = (i_cmd.load_wr && w_load_ok) || (i_cmd.finish && r_have);
    assign w_wr_addr = i_cmd.load_wr ? IDX_W'(i_item.block_index) : r_best_idx;
    assign w_wr_data = i_cmd.load_wr ? i_item.amount : w_diff;

    bfa_ram #(
        .WIDTH (AMT_W),
        .DEPTH (MAX_BLOCKS),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.scan_rd),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= '0;
            r_rd_valid    <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_block_count <= i_cfg_data;
            end
            r_rd_valid <= i_cmd.scan_rd;
            r_done     <= i_cmd.load_wr || i_cmd.finish;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_start) begin
            r_amount   <= i_item.amount;
            r_addr     <= '0;
            r_limit    <= w_limit;
            r_have     <= 1'b0;
            r_best_idx <= '0;
        end else begin
            if (i_cmd.scan_rd) begin
                r_addr <= r_addr + IDX_W'(1);
            end
            if (r_rd_valid && w_better) begin
                r_have     <= 1'b1;
                r_best_idx <= r_rd_idx;
                r_best_cap <= w_rd_data;
            end
        end
        if (i_cmd.scan_rd) begin
            r_rd_idx <= r_addr;
        end
        if (i_cmd.load_wr) begin
            r_result <= '0;
        end else if (i_cmd.finish) begin
            r_result.found        <= r_have;
            r_result.chosen_block <= r_have ? IDX_FIELD_W'(r_best_idx) : '0;
            r_result.left_over    <= r_have ? w_diff : '0;
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

// ===== sv/best_fit_block_allocator.sv =====
// Top level of the best-fit block allocator: controller, datapath and checks.
// Load transaction: result strobe on the cycle after accept; busy stays low.
// Request transaction: N = min(block_count, MAX_BLOCKS); the scan reads N RAM
// entries, one per cycle, through the single read port, then DRAIN and FINISH
// give the result (FINISH alone when N is 0); next accept on the result cycle.
// Results cannot be stalled. Reset (synchronous, active low) clears block_count
// and the control state; the capacity table is undefined until loaded.
`include "best_fit_block_allocator_macros.svh"

module best_fit_block_allocator #(
    parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bfa_pkg::t_in_item         i_item,
    input  logic                      i_cfg_we,
    input  logic [bfa_pkg::CFG_W-1:0] i_cfg_data,
    output bfa_pkg::t_out_item        o_result,
    output logic                      o_done
);
    import bfa_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_accept;

    // A transaction is taken when start is high and the block is not busy.
    assign w_accept = start && !busy;

    // Sequence load and request transactions; drive the datapath by command.
    bfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_item.op),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // Hold the capacity table, scan it and write back the chosen entry.
    bfa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_result   (o_result),
        .o_done     (o_done)
    );

    // A load always answers on the next cycle.
    `BFA_ASSERT_NEXT(a_load_done, i_clk, i_rst_n, w_accept && (i_item.op == OP_LOAD), o_done)
    // A request keeps the block busy until its scan completes.
    `BFA_ASSERT_NEXT(a_req_busy, i_clk, i_rst_n, w_accept && (i_item.op == OP_REQ), busy)
    // Results only appear once the controller has returned to idle.
    `BFA_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    // A miss reports zero index and zero capacity.
    `BFA_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, o_done && !o_result.found, (o_result.chosen_block == '0) && (o_result.left_over == '0))

endmodule
